// ===== rtl/core/tpcl_pkg.sv =====
// Package for the thermal PI current limiter: shared types, register indexes,
// fault codes, reset values and arithmetic constants. No dependencies.
package tpcl_pkg;

  // Configuration register indexes
  localparam logic [3:0] CFG_HOLD_TEMP     = 4'd0;
  localparam logic [3:0] CFG_SHUTDOWN_TEMP = 4'd1;
  localparam logic [3:0] CFG_TURBO_TEMP    = 4'd2;
  localparam logic [3:0] CFG_MIN_CURRENT   = 4'd3;

  // Configuration reset values
  localparam logic [6:0]  HOLD_TEMP_RST     = 7'd53;
  localparam logic [6:0]  SHUTDOWN_TEMP_RST = 7'd75;
  localparam logic [6:0]  TURBO_TEMP_RST    = 7'd60;
  localparam logic [14:0] MIN_CURRENT_RST   = 15'd900;

  // Fault codes
  localparam logic [1:0] FAULT_CLEAR  = 2'd0;
  localparam logic [1:0] FAULT_SENSOR = 2'd1;
  localparam logic [1:0] FAULT_HOT    = 2'd2;

  // Temperature thresholds (10-bit signed working width)
  localparam logic signed [9:0] TEMP_HYST    = 10'sd10;
  localparam logic signed [9:0] CLEAR_MARGIN = 10'sd20;

  // Regulator limits
  localparam logic signed [16:0] PROT_FULL  = 17'sd18000;
  localparam logic signed [16:0] INTEG_FULL = 17'sd12000;
  localparam logic signed [16:0] INTEG_MIN  = -17'sd12000;
  localparam logic [14:0]        CUR_STEP   = 15'd6000;

  // Limit scaling: 360000 = 64 * 5625, divide by 5625 through a reciprocal
  localparam logic signed [20:0] LIMIT_SCALE = 21'sd360000;
  localparam logic [28:0]        DIV_CONST   = 29'd5625;
  localparam logic [27:0]        DIV_RECIP   = 28'd195468733;

  typedef struct packed {
    logic               limit;
    logic               block;
    logic               exit;
    logic [1:0]         fault;
    logic [14:0]        prop;
    logic signed [14:0] integ;
  } state_t;

  typedef struct packed {
    logic       limit;
    logic       block;
    logic       exit;
    logic [1:0] fault;
    logic       off;
  } flags_t;

  // Proportional gain: present current / 6000 + 1
  function automatic logic [3:0] cur_gain(input logic [14:0] cur);
    logic [3:0] g;
    g = 4'd1;
    for (int k = 1; k <= 5; k++) begin
      if (cur >= 15'(k * int'(CUR_STEP))) begin
        g = 4'(k + 1);
      end
    end
    return g;
  endfunction

endpackage

// ===== rtl/core/tpcl_update.sv =====
// State update for one tick: hysteresis flags, fault latch and PI accumulators.
// Purely combinational. Depends on tpcl_pkg.
module tpcl_update (
  input  tpcl_pkg::state_t   st_i,
  input  logic signed [7:0]  temperature_i,
  input  logic               sensor_ok_i,
  input  logic               step_down_needed_i,
  input  logic [14:0]        present_current_i,
  input  logic [6:0]         hold_temp_i,
  input  logic [6:0]         shutdown_temp_i,
  input  logic [6:0]         turbo_block_temp_i,
  output tpcl_pkg::state_t   st_o,
  output logic               off_o
);

  logic signed [9:0]  t_s;
  logic signed [9:0]  hold_s;
  logic signed [9:0]  shut_s;
  logic signed [9:0]  blk_s;
  logic signed [9:0]  err;
  logic signed [13:0] pterm;
  logic signed [16:0] prop_sum;
  logic signed [16:0] integ_sum;
  logic [3:0]         gain;

  assign t_s    = 10'(temperature_i);
  assign hold_s = $signed({3'b000, hold_temp_i});
  assign shut_s = $signed({3'b000, shutdown_temp_i});
  assign blk_s  = $signed({3'b000, turbo_block_temp_i});
  assign gain   = tpcl_pkg::cur_gain(present_current_i);
  assign err    = t_s - hold_s;
  assign pterm  = err * $signed({1'b0, gain});

  always_comb begin
    st_o  = st_i;
    off_o = 1'b0;
    prop_sum  = $signed({2'b00, st_i.prop});
    integ_sum = 17'(st_i.integ) + 17'(err);
    if (err > 10'sd1 || err < -10'sd1) begin
      prop_sum = prop_sum + 17'(pterm);
    end
    if (prop_sum > tpcl_pkg::PROT_FULL) begin
      prop_sum = tpcl_pkg::PROT_FULL;
    end else if (prop_sum < 17'sd0) begin
      prop_sum = 17'sd0;
    end
    if (integ_sum > tpcl_pkg::INTEG_FULL) begin
      integ_sum = tpcl_pkg::INTEG_FULL;
    end else if (integ_sum < tpcl_pkg::INTEG_MIN) begin
      integ_sum = tpcl_pkg::INTEG_MIN;
    end

    if (!sensor_ok_i) begin
      st_o.fault = tpcl_pkg::FAULT_SENSOR;
    end else begin
      if (t_s > shut_s - tpcl_pkg::TEMP_HYST) begin
        st_o.exit = 1'b1;
      end
      if (t_s > blk_s) begin
        st_o.block = 1'b1;
      end else if (t_s < blk_s - tpcl_pkg::TEMP_HYST) begin
        st_o.block = 1'b0;
      end
      if (st_o.exit && !st_o.block) begin
        st_o.exit = 1'b0;
      end

      if (t_s > shut_s) begin
        // overheat: latch unless a sensor fault holds, freeze the regulator
        if (st_i.fault != tpcl_pkg::FAULT_SENSOR) begin
          st_o.fault = tpcl_pkg::FAULT_HOT;
        end
      end else begin
        if (t_s < shut_s - tpcl_pkg::CLEAR_MARGIN &&
            st_i.fault == tpcl_pkg::FAULT_HOT) begin
          st_o.fault = tpcl_pkg::FAULT_CLEAR;
          off_o      = 1'b1;
        end
        if (!step_down_needed_i) begin
          st_o.limit = 1'b0;
        end else if (t_s > hold_s) begin
          st_o.limit = 1'b1;
        end else if (t_s < hold_s - tpcl_pkg::TEMP_HYST) begin
          st_o.limit = 1'b0;
        end
        if (!st_o.limit) begin
          st_o.prop  = '0;
          st_o.integ = '0;
        end else if (present_current_i != '0) begin
          st_o.prop  = 15'(prop_sum);
          st_o.integ = 15'(integ_sum);
        end
      end
    end
  end

endmodule

// ===== rtl/core/thermal_pi_current_limiter_core.sv =====
// Top level of the thermal PI current limiter: input register, state update,
// pipelined limit scaling and result register. Depends on tpcl_pkg, tpcl_update.
//
//   channel | handshake                  | payload
//   --------+----------------------------+-----------------------------------------
//   input   | in_valid_i / in_ready_o    | temperature, sensor_ok, step_down_needed,
//           |                            | present_current, request_current
//   result  | out_valid_o / out_ready_i  | limited_current, limit_active,
//           |                            | turbo_blocked, turbo_force_exit,
//           |                            | fault_code, request_off
//   config  | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// One item per cycle sustained while the output is not stalled; the rate is set
// by the state recurrence, which closes in the update stage; the scaling runs
// behind it in five further stages.
// Reset clears the regulator state, loads register defaults and empties the pipe.
// A stalled result holds; bubbles collapse, so input is refused only when every
// stage is full behind a stalled output.
module thermal_pi_current_limiter_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [3:0]         cfg_index_i,
  input  logic [14:0]        cfg_data_i,
  // input items
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [7:0]  temperature_i,
  input  logic               sensor_ok_i,
  input  logic               step_down_needed_i,
  input  logic [14:0]        present_current_i,
  input  logic signed [15:0] request_current_i,
  // result items
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] limited_current_o,
  output logic               limit_active_o,
  output logic               turbo_blocked_o,
  output logic               turbo_force_exit_o,
  output logic [1:0]         fault_code_o,
  output logic               request_off_o
);

  // stage 0 input register ... stage 6 result register
  localparam int NST = 7;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [6:0]  hold_temp_q, shutdown_temp_q, turbo_temp_q;
  logic [14:0] min_current_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_temp_q     <= tpcl_pkg::HOLD_TEMP_RST;
      shutdown_temp_q <= tpcl_pkg::SHUTDOWN_TEMP_RST;
      turbo_temp_q    <= tpcl_pkg::TURBO_TEMP_RST;
      min_current_q   <= tpcl_pkg::MIN_CURRENT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tpcl_pkg::CFG_HOLD_TEMP:     hold_temp_q     <= cfg_data_i[6:0];
        tpcl_pkg::CFG_SHUTDOWN_TEMP: shutdown_temp_q <= cfg_data_i[6:0];
        tpcl_pkg::CFG_TURBO_TEMP:    turbo_temp_q    <= cfg_data_i[6:0];
        tpcl_pkg::CFG_MIN_CURRENT:   min_current_q   <= cfg_data_i;
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: stage k passes its item on when the next stage is free
  // or passing its own on.
  // ---------------------------------------------------------------------------
  logic [NST-1:0] vld_q, vld_d, go;
  logic           in_acc;

  always_comb begin
    go[NST-1] = vld_q[NST-1] && out_ready_i;
    for (int k = NST - 2; k >= 0; k--) begin
      go[k] = vld_q[k] && (!vld_q[k+1] || go[k+1]);
    end
  end

  assign in_ready_o = !vld_q[0] || go[0];
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    vld_d[0] = in_acc || (vld_q[0] && !go[0]);
    for (int k = 1; k < NST; k++) begin
      vld_d[k] = go[k-1] || (vld_q[k] && !go[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: input register
  // ---------------------------------------------------------------------------
  logic signed [7:0]  t0_q;
  logic               ok0_q, step0_q;
  logic [14:0]        cur0_q;
  logic signed [15:0] req0_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      t0_q    <= temperature_i;
      ok0_q   <= sensor_ok_i;
      step0_q <= step_down_needed_i;
      cur0_q  <= present_current_i;
      req0_q  <= request_current_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Regulator state: advance once per item as it leaves stage 0
  // ---------------------------------------------------------------------------
  tpcl_pkg::state_t st_q, st_d;
  logic             off_d;

  tpcl_update u_update (
    .st_i               (st_q),
    .temperature_i      (t0_q),
    .sensor_ok_i        (ok0_q),
    .step_down_needed_i (step0_q),
    .present_current_i  (cur0_q),
    .hold_temp_i        (hold_temp_q),
    .shutdown_temp_i    (shutdown_temp_q),
    .turbo_block_temp_i (turbo_temp_q),
    .st_o               (st_d),
    .off_o              (off_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (go[0]) begin
      st_q <= st_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: updated state and request
  // ---------------------------------------------------------------------------
  tpcl_pkg::flags_t   flg1_q;
  logic [14:0]        p1_q;
  logic signed [14:0] i1_q;
  logic signed [15:0] req1_q;

  always_ff @(posedge clk_i) begin
    if (go[0]) begin
      flg1_q <= '{limit: st_d.limit, block: st_d.block, exit: st_d.exit,
                  fault: st_d.fault, off: off_d};
      p1_q   <= st_d.prop;
      i1_q   <= st_d.integ;
      req1_q <= req0_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: pass-through decision, remaining share and span above minimum
  // ---------------------------------------------------------------------------
  logic signed [16:0] req_w, mn_w, diff_w;
  logic signed [20:0] x_raw, x_cl;
  logic               byp2_d, byp2_q;
  logic signed [15:0] bval2_d, bval2_q;
  tpcl_pkg::flags_t   flg2_q;
  logic [14:0]        diff2_q;
  logic [18:0]        y2_q;

  assign req_w  = 17'(req1_q);
  assign mn_w   = $signed({2'b00, min_current_q});
  assign diff_w = req_w - mn_w;
  assign x_raw  = $signed({6'b0, p1_q}) * 21'sd20 + 21'(i1_q) * 21'sd3;

  always_comb begin
    if (x_raw < 21'sd0) begin
      x_cl = 21'sd0;
    end else if (x_raw > tpcl_pkg::LIMIT_SCALE) begin
      x_cl = tpcl_pkg::LIMIT_SCALE;
    end else begin
      x_cl = x_raw;
    end
    // pass the request when idle or non-positive, floor it at the minimum
    if (!flg1_q.limit || req1_q <= 16'sd0) begin
      byp2_d  = 1'b1;
      bval2_d = req1_q;
    end else begin
      byp2_d  = req_w < mn_w;
      bval2_d = $signed({1'b0, min_current_q});
    end
  end

  always_ff @(posedge clk_i) begin
    if (go[1]) begin
      flg2_q  <= flg1_q;
      byp2_q  <= byp2_d;
      bval2_q <= bval2_d;
      diff2_q <= 15'(diff_w);
      y2_q    <= 19'(tpcl_pkg::LIMIT_SCALE - x_cl);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: span times remaining share
  // ---------------------------------------------------------------------------
  tpcl_pkg::flags_t   flg3_q;
  logic               byp3_q;
  logic signed [15:0] bval3_q;
  logic [33:0]        prod3_q;

  always_ff @(posedge clk_i) begin
    if (go[2]) begin
      flg3_q  <= flg2_q;
      byp3_q  <= byp2_q;
      bval3_q <= bval2_q;
      prod3_q <= 34'(diff2_q) * 34'(y2_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: drop the power-of-two factor, multiply by the reciprocal of 5625
  // ---------------------------------------------------------------------------
  tpcl_pkg::flags_t   flg4_q;
  logic               byp4_q;
  logic signed [15:0] bval4_q;
  logic [27:0]        n4_q;
  logic [55:0]        p4_q;

  always_ff @(posedge clk_i) begin
    if (go[3]) begin
      flg4_q  <= flg3_q;
      byp4_q  <= byp3_q;
      bval4_q <= bval3_q;
      n4_q    <= prod3_q[33:6];
      p4_q    <= 56'(prod3_q[33:6]) * 56'(tpcl_pkg::DIV_RECIP);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: quotient estimate (exact or one short) and its back product
  // ---------------------------------------------------------------------------
  tpcl_pkg::flags_t   flg5_q;
  logic               byp5_q;
  logic signed [15:0] bval5_q;
  logic [27:0]        n5_q;
  logic [15:0]        q5_q;
  logic [28:0]        qd5_q;

  always_ff @(posedge clk_i) begin
    if (go[4]) begin
      flg5_q  <= flg4_q;
      byp5_q  <= byp4_q;
      bval5_q <= bval4_q;
      n5_q    <= n4_q;
      q5_q    <= p4_q[55:40];
      qd5_q   <= 29'(p4_q[55:40]) * tpcl_pkg::DIV_CONST;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: correct the quotient, add the minimum, result register
  // ---------------------------------------------------------------------------
  logic               q_inc;
  logic [15:0]        lim_scaled;
  logic signed [15:0] lim_q;
  tpcl_pkg::flags_t   flg6_q;

  assign q_inc      = 30'(n5_q) >= (30'(qd5_q) + 30'(tpcl_pkg::DIV_CONST));
  assign lim_scaled = {1'b0, min_current_q} + q5_q + 16'(q_inc);

  always_ff @(posedge clk_i) begin
    if (go[5]) begin
      flg6_q <= flg5_q;
      lim_q  <= byp5_q ? bval5_q : $signed(lim_scaled);
    end
  end

  assign out_valid_o        = vld_q[NST-1];
  assign limited_current_o  = lim_q;
  assign limit_active_o     = flg6_q.limit;
  assign turbo_blocked_o    = flg6_q.block;
  assign turbo_force_exit_o = flg6_q.exit;
  assign fault_code_o       = flg6_q.fault;
  assign request_off_o      = flg6_q.off;

endmodule

// ===== rtl/core/tpcl_checker.sv =====
// Port-level checks for the thermal PI current limiter, bound to the top level.
// Depends on tpcl_pkg and thermal_pi_current_limiter_core.
module tpcl_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       turbo_blocked_o,
  input logic       turbo_force_exit_o,
  input logic [1:0] fault_code_o,
  input logic       request_off_o
);

  // forced exit is only ever held together with a turbo block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && turbo_force_exit_o |-> turbo_blocked_o)
    else $error("force exit without turbo block");

  // the switch-off request comes only with a cleared fault
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && request_off_o |-> fault_code_o == tpcl_pkg::FAULT_CLEAR)
    else $error("request off with fault still latched");

  // no unused fault code reaches the port
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> fault_code_o == tpcl_pkg::FAULT_CLEAR ||
                    fault_code_o == tpcl_pkg::FAULT_SENSOR ||
                    fault_code_o == tpcl_pkg::FAULT_HOT)
    else $error("invalid fault code");

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

endmodule

bind thermal_pi_current_limiter_core tpcl_checker u_tpcl_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .turbo_blocked_o    (turbo_blocked_o),
  .turbo_force_exit_o (turbo_force_exit_o),
  .fault_code_o       (fault_code_o),
  .request_off_o      (request_off_o)
);
